>>> rtl/assert_macros.svh
// assertion macros used by the rtl of the reserved ring block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/rrol_pkg.sv
// shared types, sizes and codes of the reserved ring block
// no dependencies
package rrol_pkg;

    localparam int RING_DEPTH         = 64;
    localparam int REPLY_LIST_DEPTH   = 16;
    localparam int CLEANUP_LIST_DEPTH = 16;

    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_FW = $clog2(RING_DEPTH + 1);
    localparam int RL_AW   = (REPLY_LIST_DEPTH > 1) ? $clog2(REPLY_LIST_DEPTH) : 1;
    localparam int RL_FW   = $clog2(REPLY_LIST_DEPTH + 1);
    localparam int CL_AW   = (CLEANUP_LIST_DEPTH > 1) ? $clog2(CLEANUP_LIST_DEPTH) : 1;
    localparam int CL_FW   = $clog2(CLEANUP_LIST_DEPTH + 1);
    // width of the reserve threshold sum
    localparam int TH_W    = $clog2(RING_DEPTH + 128);

    // one stored entry, destination in the lowest bits
    typedef struct packed {
        logic [63:0] data;
        logic [15:0] len;
        logic [1:0]  origin;
        logic [7:0]  kind;
        logic [15:0] dest;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [6:0]  reply_reserve;
        logic [15:0] payload_limit;
        logic [7:0]  reply_type_code;
        logic [7:0]  request_type_code;
    } t_cfg;

    // register indexes
    localparam logic [1:0] REG_RESERVE   = 2'd0;
    localparam logic [1:0] REG_LIMIT     = 2'd1;
    localparam logic [1:0] REG_REPLY_TC  = 2'd2;
    localparam logic [1:0] REG_REQUEST_TC = 2'd3;

    // operation codes
    localparam logic [2:0] MODE_REQUEST = 3'd0;
    localparam logic [2:0] MODE_REPLY   = 3'd1;
    localparam logic [2:0] MODE_CLEANUP = 3'd2;
    localparam logic [2:0] MODE_DEQUEUE = 3'd3;
    localparam logic [2:0] MODE_DRAIN   = 3'd4;
    localparam logic [2:0] MODE_REQUEUE = 3'd5;

    // producer classes
    localparam logic [1:0] ORIG_BACKEND = 2'd0;
    localparam logic [1:0] ORIG_REPLY   = 2'd1;
    localparam logic [1:0] ORIG_CLEANUP = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_REPLY_DEF    = 3'd1;
    localparam logic [2:0] EV_REPLY_DROP   = 3'd2;
    localparam logic [2:0] EV_CLEANUP_DEF  = 3'd3;
    localparam logic [2:0] EV_CLEANUP_DROP = 3'd4;
    localparam logic [2:0] EV_LEN_REJECT   = 3'd5;

endpackage

>>> rtl/rrol_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module rrol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read, read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rrol_regs.sv
// configuration register file behind the apb-style port
// depends on rrol_pkg
module rrol_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output rrol_pkg::t_cfg   o_cfg
);

    rrol_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_reserve     <= 7'd8;
            r_cfg.payload_limit     <= 16'd8;
            r_cfg.reply_type_code   <= 8'd1;
            r_cfg.request_type_code <= 8'd0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                rrol_pkg::REG_RESERVE:    r_cfg.reply_reserve     <= pwdata[6:0];
                rrol_pkg::REG_LIMIT:      r_cfg.payload_limit     <= pwdata[15:0];
                rrol_pkg::REG_REPLY_TC:   r_cfg.reply_type_code   <= pwdata[7:0];
                rrol_pkg::REG_REQUEST_TC: r_cfg.request_type_code <= pwdata[7:0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[3:2])
            rrol_pkg::REG_RESERVE:    prdata = {25'd0, r_cfg.reply_reserve};
            rrol_pkg::REG_LIMIT:      prdata = {16'd0, r_cfg.payload_limit};
            rrol_pkg::REG_REPLY_TC:   prdata = {24'd0, r_cfg.reply_type_code};
            rrol_pkg::REG_REQUEST_TC: prdata = {24'd0, r_cfg.request_type_code};
        endcase
    end

endmodule

>>> rtl/reserved_ring_with_overflow_lists.sv
// Outbound message queue: a main ring shared by backend requests, replies and
// cleanup releases, with one overflow list each for replies and cleanups, all
// held in synchronous rams. One request at a time is worked by a sequencer:
// enqueue, requeue and empty dequeue pass the execute and finish states, a
// dequeue that finds an entry also a ring read state, and a drain a list read
// state followed by a ring write state for every moved entry, until each list
// is empty, stopped by an overlong head or the ring is full. A result that
// cannot leave because the previous one is still waiting holds the sequencer
// in the finish state. The result waits in an output register while the next
// item is taken in. No clearing pass is needed after reset.
// depends on rrol_pkg, rrol_regs, rrol_ram and assert_macros.svh
`include "assert_macros.svh"

module reserved_ring_with_overflow_lists (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input items
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // dest_node, msg_kind, origin_class, msg_len, payload_word, zero pad
    input  logic [111:0]  s_axis_tdata,
    // mode
    input  logic [2:0]    s_axis_tuser,
    // result items
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_dest, out_kind, out_origin, out_len, out_payload, moved_count,
    // ring_depth, reply_depth, cleanup_depth, zero pad
    output logic [135:0]  m_axis_tdata,
    // ok, event_res
    output logic [3:0]    m_axis_tuser
);

    localparam int RAW = rrol_pkg::RING_AW;
    localparam int RFW = rrol_pkg::RING_FW;
    localparam int LAW = rrol_pkg::RL_AW;
    localparam int LFW = rrol_pkg::RL_FW;
    localparam int CAW = rrol_pkg::CL_AW;
    localparam int CFW = rrol_pkg::CL_FW;
    localparam int THW = rrol_pkg::TH_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_DEQ  = 6'b000100,
        S_DRD  = 6'b001000,
        S_DWR  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    rrol_pkg::t_cfg   cfg;

    t_state           r_state, n_state;
    logic [2:0]       r_mode, n_mode;
    rrol_pkg::t_entry r_ent, n_ent;
    logic [RAW-1:0]   r_ring_wr, n_ring_wr, r_ring_rd, n_ring_rd;
    logic [RFW-1:0]   r_ring_fill, n_ring_fill;
    logic [LAW-1:0]   r_rl_wr, n_rl_wr, r_rl_rd, n_rl_rd;
    logic [LFW-1:0]   r_rl_fill, n_rl_fill;
    logic [CAW-1:0]   r_cl_wr, n_cl_wr, r_cl_rd, n_cl_rd;
    logic [CFW-1:0]   r_cl_fill, n_cl_fill;
    logic             r_dsel, n_dsel;
    logic             r_res_ok, n_res_ok;
    rrol_pkg::t_entry r_res_ent, n_res_ent;
    logic [5:0]       r_res_moved, n_res_moved;
    logic [2:0]       r_res_ev, n_res_ev;
    logic             r_ovalid, n_ovalid;
    logic [135:0]     r_odata, n_odata;
    logic [3:0]       r_ouser, n_ouser;

    logic             s_acc, m_acc;
    logic             ring_we, rl_we, cl_we;
    rrol_pkg::t_entry ring_wdata, ring_rdata, rl_rdata, cl_rdata, drain_ent;
    rrol_pkg::t_entry stamped;
    logic             ring_room, refuse, len_bad;
    logic             rl_put, cl_put;

    rrol_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rrol_ram #(.WIDTH(rrol_pkg::ENTRY_W), .DEPTH(rrol_pkg::RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_ring_wr),
        .i_wdata (ring_wdata),
        .i_raddr (r_ring_rd),
        .o_rdata (ring_rdata)
    );

    rrol_ram #(.WIDTH(rrol_pkg::ENTRY_W), .DEPTH(rrol_pkg::REPLY_LIST_DEPTH)) u_reply (
        .i_clk   (i_clk),
        .i_we    (rl_we),
        .i_waddr (r_rl_wr),
        .i_wdata (stamped),
        .i_raddr (r_rl_rd),
        .o_rdata (rl_rdata)
    );

    rrol_ram #(.WIDTH(rrol_pkg::ENTRY_W), .DEPTH(rrol_pkg::CLEANUP_LIST_DEPTH)) u_cleanup (
        .i_clk   (i_clk),
        .i_we    (cl_we),
        .i_waddr (r_cl_wr),
        .i_wdata (stamped),
        .i_raddr (r_cl_rd),
        .o_rdata (cl_rdata)
    );

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = r_ovalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // common conditions on the held item
    assign ring_room = r_ring_fill < RFW'(rrol_pkg::RING_DEPTH);
    assign refuse    = (THW'(r_ring_fill) + THW'(cfg.reply_reserve)) >=
                       THW'(rrol_pkg::RING_DEPTH);
    assign len_bad   = r_ent.len > cfg.payload_limit;
    assign drain_ent = r_dsel ? cl_rdata : rl_rdata;

    // class stamping of kind and origin
    always_comb begin
        stamped = r_ent;
        priority if (r_mode == rrol_pkg::MODE_REQUEST) begin
            stamped.kind   = cfg.request_type_code;
            stamped.origin = rrol_pkg::ORIG_BACKEND;
        end else if (r_mode == rrol_pkg::MODE_REPLY) begin
            stamped.kind   = cfg.reply_type_code;
            stamped.origin = rrol_pkg::ORIG_REPLY;
        end else if (r_mode == rrol_pkg::MODE_CLEANUP) begin
            stamped.kind   = cfg.request_type_code;
            stamped.origin = rrol_pkg::ORIG_CLEANUP;
        end else if (r_mode == rrol_pkg::MODE_REQUEUE &&
                     r_ent.origin == rrol_pkg::ORIG_REPLY) begin
            stamped.kind   = cfg.reply_type_code;
        end else if (r_mode == rrol_pkg::MODE_REQUEUE &&
                     r_ent.origin == rrol_pkg::ORIG_CLEANUP) begin
            stamped.kind   = cfg.request_type_code;
        end else begin
            stamped = r_ent;
        end
    end

    // sequencer and pointer updates
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_ent       = r_ent;
        n_ring_wr   = r_ring_wr;
        n_ring_rd   = r_ring_rd;
        n_ring_fill = r_ring_fill;
        n_rl_wr     = r_rl_wr;
        n_rl_rd     = r_rl_rd;
        n_rl_fill   = r_rl_fill;
        n_cl_wr     = r_cl_wr;
        n_cl_rd     = r_cl_rd;
        n_cl_fill   = r_cl_fill;
        n_dsel      = r_dsel;
        n_res_ok    = r_res_ok;
        n_res_ent   = r_res_ent;
        n_res_moved = r_res_moved;
        n_res_ev    = r_res_ev;
        n_ovalid    = m_acc ? 1'b0 : r_ovalid;
        n_odata     = r_odata;
        n_ouser     = r_ouser;
        ring_we     = 1'b0;
        ring_wdata  = stamped;
        rl_put      = 1'b0;
        cl_put      = 1'b0;
        rl_we       = 1'b0;
        cl_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_mode      = s_axis_tuser;
                    n_ent       = rrol_pkg::t_entry'(s_axis_tdata[rrol_pkg::ENTRY_W-1:0]);
                    n_dsel      = 1'b0;
                    n_res_ok    = 1'b0;
                    n_res_ent   = '0;
                    n_res_moved = 6'd0;
                    n_res_ev    = rrol_pkg::EV_NONE;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                unique case (r_mode)
                    rrol_pkg::MODE_REQUEST: begin
                        if (!refuse) begin
                            if (len_bad) begin
                                n_res_ev = rrol_pkg::EV_LEN_REJECT;
                            end else begin
                                ring_we  = 1'b1;
                                n_res_ok = 1'b1;
                            end
                        end
                    end
                    rrol_pkg::MODE_REPLY, rrol_pkg::MODE_CLEANUP: begin
                        if (len_bad) begin
                            n_res_ev = rrol_pkg::EV_LEN_REJECT;
                        end else if (ring_room) begin
                            ring_we  = 1'b1;
                            n_res_ok = 1'b1;
                        end else if (r_mode == rrol_pkg::MODE_REPLY) begin
                            rl_put = 1'b1;
                        end else begin
                            cl_put = 1'b1;
                        end
                    end
                    rrol_pkg::MODE_DEQUEUE: begin
                        if (r_ring_fill != '0) begin
                            n_state = S_DEQ;
                        end
                    end
                    rrol_pkg::MODE_DRAIN: begin
                        n_state = S_DRD;
                    end
                    rrol_pkg::MODE_REQUEUE: begin
                        if (r_ent.origin == rrol_pkg::ORIG_REPLY ||
                            r_ent.origin == rrol_pkg::ORIG_CLEANUP) begin
                            if (len_bad) begin
                                n_res_ev = rrol_pkg::EV_LEN_REJECT;
                            end else if (r_ent.origin == rrol_pkg::ORIG_REPLY) begin
                                rl_put = 1'b1;
                            end else begin
                                cl_put = 1'b1;
                            end
                        end else if (ring_room) begin
                            if (len_bad) begin
                                n_res_ev = rrol_pkg::EV_LEN_REJECT;
                            end else begin
                                ring_we  = 1'b1;
                                n_res_ok = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_DEQ: begin
                // ring head read issued in the execute cycle
                n_res_ent   = ring_rdata;
                n_res_ok    = 1'b1;
                n_ring_rd   = (r_ring_rd == RAW'(rrol_pkg::RING_DEPTH - 1)) ?
                              '0 : r_ring_rd + 1'b1;
                n_ring_fill = r_ring_fill - 1'b1;
                n_state     = S_FIN;
            end
            S_DRD: begin
                // list head read runs every cycle at the read pointer
                if (ring_room && (r_dsel ? (r_cl_fill != '0) : (r_rl_fill != '0))) begin
                    n_state = S_DWR;
                end else if (!r_dsel) begin
                    n_dsel = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DWR: begin
                if (drain_ent.len > cfg.payload_limit) begin
                    // overlong head stays, go on to the cleanup list or finish
                    if (!r_dsel) begin
                        n_dsel  = 1'b1;
                        n_state = S_DRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    ring_we     = 1'b1;
                    ring_wdata  = drain_ent;
                    n_res_moved = r_res_moved + 6'd1;
                    n_state     = S_DRD;
                    if (r_dsel) begin
                        n_cl_rd   = (r_cl_rd == CAW'(rrol_pkg::CLEANUP_LIST_DEPTH - 1)) ?
                                    '0 : r_cl_rd + 1'b1;
                        n_cl_fill = r_cl_fill - 1'b1;
                    end else begin
                        n_rl_rd   = (r_rl_rd == LAW'(rrol_pkg::REPLY_LIST_DEPTH - 1)) ?
                                    '0 : r_rl_rd + 1'b1;
                        n_rl_fill = r_rl_fill - 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {7'd0, 5'(r_cl_fill), 5'(r_rl_fill), 7'(r_ring_fill),
                                r_res_moved, r_res_ent};
                    n_ouser  = {r_res_ev, r_res_ok};
                    n_state  = S_IDLE;
                end
            end
        endcase

        // ring write pointer and fill
        if (ring_we) begin
            n_ring_wr   = (r_ring_wr == RAW'(rrol_pkg::RING_DEPTH - 1)) ?
                          '0 : r_ring_wr + 1'b1;
            n_ring_fill = r_ring_fill + 1'b1;
        end

        // reply overflow list, oldest dropped when full
        if (rl_put) begin
            rl_we    = 1'b1;
            n_rl_wr  = (r_rl_wr == LAW'(rrol_pkg::REPLY_LIST_DEPTH - 1)) ?
                       '0 : r_rl_wr + 1'b1;
            if (r_rl_fill >= LFW'(rrol_pkg::REPLY_LIST_DEPTH)) begin
                n_rl_rd  = (r_rl_rd == LAW'(rrol_pkg::REPLY_LIST_DEPTH - 1)) ?
                           '0 : r_rl_rd + 1'b1;
                n_res_ev = rrol_pkg::EV_REPLY_DROP;
            end else begin
                n_rl_fill = r_rl_fill + 1'b1;
                n_res_ev  = rrol_pkg::EV_REPLY_DEF;
            end
        end

        // cleanup overflow list, oldest dropped when full
        if (cl_put) begin
            cl_we    = 1'b1;
            n_cl_wr  = (r_cl_wr == CAW'(rrol_pkg::CLEANUP_LIST_DEPTH - 1)) ?
                       '0 : r_cl_wr + 1'b1;
            if (r_cl_fill >= CFW'(rrol_pkg::CLEANUP_LIST_DEPTH)) begin
                n_cl_rd  = (r_cl_rd == CAW'(rrol_pkg::CLEANUP_LIST_DEPTH - 1)) ?
                           '0 : r_cl_rd + 1'b1;
                n_res_ev = rrol_pkg::EV_CLEANUP_DROP;
            end else begin
                n_cl_fill = r_cl_fill + 1'b1;
                n_res_ev  = rrol_pkg::EV_CLEANUP_DEF;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring_wr   <= '0;
            r_ring_rd   <= '0;
            r_ring_fill <= '0;
            r_rl_wr     <= '0;
            r_rl_rd     <= '0;
            r_rl_fill   <= '0;
            r_cl_wr     <= '0;
            r_cl_rd     <= '0;
            r_cl_fill   <= '0;
            r_dsel      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ring_wr   <= n_ring_wr;
            r_ring_rd   <= n_ring_rd;
            r_ring_fill <= n_ring_fill;
            r_rl_wr     <= n_rl_wr;
            r_rl_rd     <= n_rl_rd;
            r_rl_fill   <= n_rl_fill;
            r_cl_wr     <= n_cl_wr;
            r_cl_rd     <= n_cl_rd;
            r_cl_fill   <= n_cl_fill;
            r_dsel      <= n_dsel;
            r_ovalid    <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_ent       <= n_ent;
        r_res_ok    <= n_res_ok;
        r_res_ent   <= n_res_ent;
        r_res_moved <= n_res_moved;
        r_res_ev    <= n_res_ev;
        r_odata     <= n_odata;
        r_ouser     <= n_ouser;
    end

    // checks
    `ASSERT_ALWAYS(a_ring_fill_bound, i_clk, i_rst_n,
        r_ring_fill <= RFW'(rrol_pkg::RING_DEPTH))
    `ASSERT_ALWAYS(a_list_fill_bound, i_clk, i_rst_n,
        (r_rl_fill <= LFW'(rrol_pkg::REPLY_LIST_DEPTH)) &&
        (r_cl_fill <= CFW'(rrol_pkg::CLEANUP_LIST_DEPTH)))
    `ASSERT_ALWAYS(a_ring_write_room, i_clk, i_rst_n, !ring_we || ring_room)
    `ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, s_acc, r_state == S_EXEC)

endmodule
